// ===== rtl/usfq_pkg.sv =====
`default_nettype none
package usfq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_NORMAL = 2'd1;
    localparam logic [1:0] CMD_URGENT = 2'd2;

    typedef struct packed {
        logic       urgent;
        logic [15:0] student;
        logic [7:0]  course;
        logic [7:0]  minutes;
    } job_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } cell_op_t;

endpackage
`default_nettype wire

// ===== rtl/usfq_cell.sv =====
`default_nettype none
module usfq_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire usfq_pkg::cell_op_t op,
    input  wire usfq_pkg::job_t  new_job,
    input  wire logic            left_valid,
    input  wire usfq_pkg::job_t  left_job,
    input  wire logic            right_valid,
    input  wire usfq_pkg::job_t  right_job,
    output logic                 valid,
    output usfq_pkg::job_t       job
);
    import usfq_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        case (op)
            CELL_HOLD:
            begin
                valid_next = valid_reg;
                job_next   = job_reg;
            end
            CELL_FROM_LEFT:
            begin
                valid_next = left_valid;
                job_next   = left_job;
            end
            CELL_FROM_RIGHT:
            begin
                valid_next = right_valid;
                job_next   = right_job;
            end
            CELL_LOAD:
            begin
                valid_next = 1'b1;
                job_next   = new_job;
            end
            default:
            begin
                valid_next = valid_reg;
                job_next   = job_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload carries no reset; a word is only read while its cell is occupied
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign valid = valid_reg;
    assign job   = job_reg;

endmodule
`default_nettype wire

// ===== rtl/urgent_first_service_queue.sv =====
`default_nettype none
// Urgent-first service queue. Each input word is one minute tick carrying no
// request, a normal request or an urgent request; each tick yields exactly one
// output word. Waiting requests sit in a row of QUEUE_DEPTH cells, cell 0 at
// the front: a normal request fills the first empty cell, an urgent request
// shifts the row back by one and takes cell 0, and a pop shifts the row toward
// the front. A request arriving while the row is full is dropped and flagged.
// When the current job has no minutes left, the front request becomes the
// current job; a job with minutes left is reported, then counts down by one.
// Rate: one tick per clock cycle while the output is not stalled. The whole row
// and the current job update in the single cycle of the accept, and the result
// lands in an output register, so a new tick is taken whenever the output
// register is empty or its word is being taken in the same cycle; the word
// appears in the cycle after the accept. No clearing pass after reset: only the
// cell occupancy flags, the current job and the output valid flag are reset.
module urgent_first_service_queue #(
    parameter int QUEUE_DEPTH = usfq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata, low bit up: student_id[15:0], course_id[7:0], service_minutes[7:0]
    input  wire logic [usfq_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [usfq_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata, low bit up: served_student[15:0], served_course[7:0], time_left[7:0]
    output logic [usfq_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser, low bit up: serving, is_urgent, dropped
    output logic [usfq_pkg::OUT_USER_W-1:0]       m_tuser
);
    import usfq_pkg::*;

    logic     accept;
    logic     push_req;
    logic     push_urgent;
    logic     full;
    logic     push_acc;
    logic     push_head_acc;
    logic     push_tail_acc;
    logic     nonempty;
    logic     pop;
    logic     pop_from_cells;
    job_t     new_job;
    job_t     pop_job;
    job_t     job_sel;

    logic     cell_valid [QUEUE_DEPTH];
    job_t     cell_job   [QUEUE_DEPTH];

    job_t     cur_reg;
    job_t     cur_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic [OUT_USER_W-1:0] out_user_next;

    // take a tick whenever the result register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // commands 0 and 3 mean no request
    assign push_req    = (s_tuser == CMD_NORMAL) || (s_tuser == CMD_URGENT);
    assign push_urgent = (s_tuser == CMD_URGENT);
    assign full        = cell_valid[QUEUE_DEPTH-1];

    assign push_acc      = push_req && !full;
    assign push_head_acc = push_acc && push_urgent;
    assign push_tail_acc = push_acc && !push_urgent;

    assign new_job.urgent  = push_urgent;
    assign new_job.student = s_tdata[15:0];
    assign new_job.course  = s_tdata[23:16];
    assign new_job.minutes = s_tdata[31:24];

    // pop sees the queue after this tick's push
    assign nonempty = cell_valid[0] || push_acc;
    assign pop      = nonempty && (cur_reg.minutes == 8'd0);

    // an urgent push that is popped at once, or a normal push into an empty
    // row that is popped at once, bypasses the cells
    assign pop_from_cells = pop && !push_head_acc && cell_valid[0];
    assign pop_job        = pop_from_cells ? cell_job[0] : new_job;
    assign job_sel        = pop ? pop_job : cur_reg;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic     prev_valid;
            logic     next_valid;
            logic     last_valid;
            logic     first_empty;
            logic     right_valid;
            job_t     right_job;
            job_t     left_job;
            logic     left_valid;
            cell_op_t op_sel;

            if (i == 0)
            begin : g_head
                assign prev_valid = 1'b1;
                assign left_valid = 1'b1;
                assign left_job   = new_job;
            end
            else
            begin : g_body
                assign prev_valid = cell_valid[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_job   = cell_job[i-1];
            end

            if (i == QUEUE_DEPTH-1)
            begin : g_tail
                assign next_valid  = 1'b0;
                assign right_valid = 1'b0;
                assign right_job   = cell_job[i];
            end
            else
            begin : g_mid
                assign next_valid  = cell_valid[i+1];
                assign right_valid = cell_valid[i+1];
                assign right_job   = cell_job[i+1];
            end

            assign last_valid  = cell_valid[i] && !next_valid;
            assign first_empty = !cell_valid[i] && prev_valid;

            always_comb
            begin
                if (accept && push_head_acc && !pop)
                begin
                    op_sel = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                end
                else if (accept && pop_from_cells)
                begin
                    // shift toward the front; a normal push lands behind the old tail
                    op_sel = (push_tail_acc && last_valid) ? CELL_LOAD : CELL_FROM_RIGHT;
                end
                else if (accept && push_tail_acc && !pop)
                begin
                    op_sel = first_empty ? CELL_LOAD : CELL_HOLD;
                end
                else
                begin
                    op_sel = CELL_HOLD;
                end
            end

            usfq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op_sel),
                .new_job     (new_job),
                .left_valid  (left_valid),
                .left_job    (left_job),
                .right_valid (right_valid),
                .right_job   (right_job),
                .valid       (cell_valid[i]),
                .job         (cell_job[i])
            );
        end
    endgenerate

    // serve the selected job and count it down
    always_comb
    begin
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            cur_next       = job_sel;
            out_valid_next = 1'b1;
            if (job_sel.minutes != 8'd0)
            begin
                cur_next.minutes = job_sel.minutes - 8'd1;
                out_data_next    = {job_sel.minutes, job_sel.course, job_sel.student};
                out_user_next    = {push_req && full, job_sel.urgent, 1'b1};
            end
            else
            begin
                out_data_next = '0;
                out_user_next = {push_req && full, 1'b0, 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

// ===== rtl/usfq_checker.sv =====
`default_nettype none
module usfq_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [usfq_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic [usfq_pkg::IN_USER_W-1:0]   s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [usfq_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic [usfq_pkg::OUT_USER_W-1:0]  m_tuser
);
    import usfq_pkg::*;

    // every accepted tick produces a word in the next cycle
    a_tick_yields_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no output word");

    // no word appears without a tick behind it
    a_no_phantom_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("output word without an accepted tick");

    // an idle minute reports no job fields
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("idle minute carries job fields");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

endmodule

bind urgent_first_service_queue usfq_checker u_usfq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
